### design/c8e_pkg.sv
`default_nettype none
package c8e_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int AW   = 12;
  localparam int CFGW = 1;

  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_EXEC  = 3'd1;
  localparam logic [2:0] FN_TICK  = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_PIXEL = 3'd4;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_UNKNOWN = 3'd1;
  localparam logic [2:0] STS_OVF    = 3'd2;
  localparam logic [2:0] STS_EMPTY  = 3'd3;
  localparam logic [2:0] STS_HALTED = 3'd4;

  localparam logic [CFGW-1:0] CFG_PROG_START = 1'd0;
  localparam logic [CFGW-1:0] CFG_FONT_START = 1'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] pc;
    logic [15:0] opcode;
    logic [7:0]  read_data;
    logic        pixel_value;
    logic        display_changed;
    logic        sound_on;
  } out_item_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SHR, ALU_SHL, ALU_PASSB
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MRD, S_PRD, S_F1, S_F2, S_F3, S_F4, S_EXE, S_WRX, S_FNT,
    S_BCDH, S_BCDT, S_BCDW, S_STA, S_STB, S_LDA, S_LDB, S_DRA, S_DRB, S_DRF,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

### design/c8e_ram.sv
`default_nettype none
module c8e_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### design/c8e_alu.sv
`default_nettype none
module c8e_alu (
  input  wire c8e_pkg::alu_op_e op_i,
  input  wire logic [15:0]      a_i,
  input  wire logic [15:0]      b_i,
  output      logic [16:0]      res_o
);

  // bit 16 carries the carry out of an add and the borrow of a subtract
  always_comb begin
    case (op_i)
      c8e_pkg::ALU_ADD:   res_o = {1'b0, a_i} + {1'b0, b_i};
      c8e_pkg::ALU_SUB:   res_o = {1'b0, a_i} - {1'b0, b_i};
      c8e_pkg::ALU_AND:   res_o = {1'b0, a_i & b_i};
      c8e_pkg::ALU_OR:    res_o = {1'b0, a_i | b_i};
      c8e_pkg::ALU_XOR:   res_o = {1'b0, a_i ^ b_i};
      c8e_pkg::ALU_SHR:   res_o = {2'b0, a_i[15:1]};
      c8e_pkg::ALU_SHL:   res_o = {a_i, 1'b0};
      c8e_pkg::ALU_PASSB: res_o = {1'b0, b_i};
      default:            res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/chip8_instruction_executor_top.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_data_i  (c8e_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i  out_data_o (c8e_pkg::out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction at a time: memory, timer and pixel items pass through DISP to
// RESP, an execute fetches (F1-F4) and runs in EXE, store/load step through
// STA/STB or LDA/LDB for each register, BCD subtracts in BCDH/BCDT, and a draw
// steps through DRA/DRB for each sprite row. The sequencer shares a single ALU.
// Reset is asynchronous; display rows and data registers carry valid bits, so
// no clearing pass is needed. A waiting result holds off new input transactions.
`default_nettype none
module chip8_instruction_executor_top #(
  parameter int STACK_DEPTH = c8e_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire c8e_pkg::in_item_t         in_data_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      c8e_pkg::out_item_t        out_data_o,
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [c8e_pkg::CFGW-1:0]  cfg_index_i,
  input  wire logic [11:0]               cfg_data_i
);

  localparam int SPW  = $clog2(STACK_DEPTH);
  localparam int MAW  = $clog2(c8e_pkg::MEMORY_BYTES);
  localparam int ROWW = $clog2(c8e_pkg::SCREEN_HEIGHT);
  localparam int COLW = $clog2(c8e_pkg::SCREEN_WIDTH);
  localparam int SW   = c8e_pkg::SCREEN_WIDTH;
  localparam int SH   = c8e_pkg::SCREEN_HEIGHT;

  c8e_pkg::state_e state_q, state_d;
  c8e_pkg::in_item_t item_q, item_d;
  c8e_pkg::out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // architectural state
  logic [11:0] pc_q, pc_d, pstart_q, pstart_d, fstart_q, fstart_d;
  logic [15:0] idx_q, idx_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [11:0] stk_q [STACK_DEPTH];
  logic stk_we;
  logic [7:0] dt_q, dt_d, st_q, st_d;
  logic halt_q, halt_d;

  // per-transaction working registers
  logic [15:0] op_q, op_d, tmp_q, tmp_d;
  logic [7:0] vx_q, vx_d, vy_q, vy_d, bt_q, bt_d, rd_q, rd_d;
  logic [3:0] bh_q, bh_d, btn_q, btn_d, cnt_q, cnt_d;
  logic [2:0] sts_q, sts_d;
  logic flag_q, flag_d, coll_q, coll_d, chg_q, chg_d, pix_q, pix_d;

  // valid bits for the register file and display rows
  logic [15:0] vval_q, vval_d;
  logic [SH-1:0] rowv_q, rowv_d, rownz_q, rownz_d;
  logic vrv_q, drv_q;

  // memory ports
  logic mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  logic v_we;
  logic [3:0] v_waddr, v_raddr;
  logic [7:0] v_wdata, v_rdata, vrd;
  logic d_we;
  logic [ROWW-1:0] d_waddr, d_raddr;
  logic [SW-1:0] d_wdata, d_rdata, drow;

  // shared ALU
  c8e_pkg::alu_op_e alu_op;
  logic [15:0] alu_a, alu_b;
  logic [16:0] alu_res;

  // decode helpers
  logic [3:0] ox, oy, on, ohi;
  logic [7:0] kk, vxe, vye;
  logic [11:0] nnn, pc2, pc4;
  logic flagop, eq8;
  logic [7:0] line, lrev;
  logic [2*SW-1:0] rot;
  logic [SW-1:0] base, mask, nrow;
  logic [ROWW-1:0] drow_addr;

  c8e_ram #(.WIDTH(8), .DEPTH(c8e_pkg::MEMORY_BYTES)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  c8e_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  c8e_ram #(.WIDTH(SW), .DEPTH(SH)) u_disp (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  c8e_alu u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .res_o(alu_res));

  assign in_stall_o  = (state_q != c8e_pkg::S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign ohi = op_q[15:12];
  assign ox  = op_q[11:8];
  assign oy  = op_q[7:4];
  assign on  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc2 = pc_q + 12'd2;
  assign pc4 = pc_q + 12'd4;
  assign vrd  = vrv_q ? v_rdata : 8'd0;
  assign drow = drv_q ? d_rdata : '0;
  assign eq8  = (alu_res[7:0] == 8'd0);
  assign flagop = (ohi == 4'h8) && (on inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE});
  // once VF has taken the flag, an operand that is VF reads the new value
  assign vxe = (flagop && ox == 4'hF) ? {7'd0, flag_q} : vx_q;
  assign vye = (flagop && oy == 4'hF) ? {7'd0, flag_q} : vy_q;
  assign drow_addr = vy_q[ROWW-1:0] + ROWW'(cnt_q);

  // sprite row: bit c of the glyph, counted from its MSB, lands on column (sx + c) mod 64
  always_comb begin
    line = mem_rdata;
    for (int i = 0; i < 8; i++) begin
      lrev[i] = line[7-i];
    end
    base = {{(SW-8){1'b0}}, lrev};
    rot  = {base, base} << vx_q[COLW-1:0];
    mask = rot[2*SW-1:SW];
    nrow = drow ^ mask;
  end

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    pc_d = pc_q; pstart_d = pstart_q; fstart_d = fstart_q;
    idx_d = idx_q; sp_d = sp_q; stk_we = 1'b0;
    dt_d = dt_q; st_d = st_q; halt_d = halt_q;
    op_d = op_q; tmp_d = tmp_q; vx_d = vx_q; vy_d = vy_q;
    bt_d = bt_q; bh_d = bh_q; btn_d = btn_q; cnt_d = cnt_q; rd_d = rd_q;
    sts_d = sts_q; flag_d = flag_q; coll_d = coll_q; chg_d = chg_q; pix_d = pix_q;
    vval_d = vval_q; rowv_d = rowv_q; rownz_d = rownz_q;
    mem_we = 1'b0; mem_waddr = item_q.mem_address; mem_wdata = item_q.mem_data;
    mem_raddr = pc_q;
    v_we = 1'b0; v_waddr = ox; v_wdata = 8'd0; v_raddr = ox;
    d_we = 1'b0; d_waddr = drow_addr; d_wdata = nrow; d_raddr = drow_addr;
    alu_op = c8e_pkg::ALU_ADD; alu_a = 16'd0; alu_b = 16'd0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        c8e_pkg::CFG_PROG_START: begin
          pstart_d = cfg_data_i;
          pc_d = cfg_data_i;
        end
        c8e_pkg::CFG_FONT_START: fstart_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      c8e_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          item_d = in_data_i;
          op_d = 16'd0; rd_d = 8'd0; pix_d = 1'b0; chg_d = 1'b0;
          sts_d = c8e_pkg::STS_OK;
          state_d = c8e_pkg::S_DISP;
        end
      end
      c8e_pkg::S_DISP: begin
        state_d = c8e_pkg::S_RESP;
        case (item_q.func)
          c8e_pkg::FN_WRITE: mem_we = 1'b1;
          c8e_pkg::FN_EXEC: begin
            if (halt_q) begin
              sts_d = c8e_pkg::STS_HALTED;
            end else begin
              mem_raddr = pc_q;
              state_d = c8e_pkg::S_F1;
            end
          end
          c8e_pkg::FN_TICK: begin
            if (st_q != 8'd0) st_d = st_q - 8'd1;
            if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
          end
          c8e_pkg::FN_READ: begin
            mem_raddr = item_q.mem_address;
            state_d = c8e_pkg::S_MRD;
          end
          c8e_pkg::FN_PIXEL: begin
            d_raddr = item_q.pixel_y;
            state_d = c8e_pkg::S_PRD;
          end
          default: ;
        endcase
      end
      c8e_pkg::S_MRD: begin
        rd_d = mem_rdata;
        state_d = c8e_pkg::S_RESP;
      end
      c8e_pkg::S_PRD: begin
        pix_d = drow[item_q.pixel_x];
        state_d = c8e_pkg::S_RESP;
      end
      c8e_pkg::S_F1: begin
        op_d[15:8] = mem_rdata;
        mem_raddr = pc_q + 12'd1;
        state_d = c8e_pkg::S_F2;
      end
      c8e_pkg::S_F2: begin
        op_d[7:0] = mem_rdata;
        v_raddr = ox;
        state_d = c8e_pkg::S_F3;
      end
      c8e_pkg::S_F3: begin
        vx_d = vrd;
        // the jump with offset wants V0 in place of Vy
        v_raddr = (ohi == 4'hB) ? 4'h0 : oy;
        state_d = c8e_pkg::S_F4;
      end
      c8e_pkg::S_F4: begin
        vy_d = vrd;
        state_d = c8e_pkg::S_EXE;
      end
      c8e_pkg::S_EXE: begin
        state_d = c8e_pkg::S_RESP;
        case (ohi)
          4'h0: begin
            if (ox == 4'h0 && kk == 8'hE0) begin
              chg_d = |rownz_q;
              rowv_d = '0;
              rownz_d = '0;
              pc_d = pc2;
            end else if (ox == 4'h0 && kk == 8'hEE) begin
              if (sp_q == '0) begin
                sts_d = c8e_pkg::STS_EMPTY;
              end else begin
                sp_d = sp_q - SPW'(1);
                pc_d = stk_q[sp_q - SPW'(1)];
              end
            end else begin
              sts_d = c8e_pkg::STS_UNKNOWN;
            end
          end
          4'h1: pc_d = nnn;
          4'h2: begin
            if (sp_q >= SPW'(STACK_DEPTH - 1)) begin
              sts_d = c8e_pkg::STS_OVF;
            end else begin
              stk_we = 1'b1;
              sp_d = sp_q + SPW'(1);
              pc_d = nnn;
            end
          end
          4'h3, 4'h4, 4'h5, 4'h9: begin
            alu_op = c8e_pkg::ALU_SUB;
            alu_a = {8'd0, vx_q};
            alu_b = (ohi == 4'h3 || ohi == 4'h4) ? {8'd0, kk} : {8'd0, vy_q};
            pc_d = ((ohi == 4'h4 || ohi == 4'h9) ? !eq8 : eq8) ? pc4 : pc2;
          end
          4'h6, 4'h7, 4'hC: state_d = c8e_pkg::S_WRX;
          4'h8: begin
            state_d = c8e_pkg::S_WRX;
            case (on)
              4'h0, 4'h1, 4'h2, 4'h3: ;
              4'h4: begin
                alu_a = {8'd0, vx_q}; alu_b = {8'd0, vy_q};
                flag_d = alu_res[8];
              end
              4'h5: begin
                alu_op = c8e_pkg::ALU_SUB;
                alu_a = {8'd0, vx_q}; alu_b = {8'd0, vy_q};
                flag_d = !alu_res[16];
              end
              4'h7: begin
                alu_op = c8e_pkg::ALU_SUB;
                alu_a = {8'd0, vy_q}; alu_b = {8'd0, vx_q};
                flag_d = !alu_res[16];
              end
              4'h6: flag_d = vx_q[0];
              4'hE: flag_d = vx_q[7];
              default: begin
                sts_d = c8e_pkg::STS_UNKNOWN;
                state_d = c8e_pkg::S_RESP;
              end
            endcase
            if (flagop) begin
              v_we = 1'b1;
              v_waddr = 4'hF;
              v_wdata = {7'd0, flag_d};
            end
          end
          4'hA: begin
            idx_d = {4'd0, nnn};
            pc_d = pc2;
          end
          4'hB: begin
            alu_a = {4'd0, nnn}; alu_b = {8'd0, vy_q};
            pc_d = alu_res[11:0];
          end
          4'hD: begin
            cnt_d = 4'd0;
            coll_d = 1'b0;
            state_d = (on == 4'd0) ? c8e_pkg::S_DRF : c8e_pkg::S_DRA;
          end
          4'hE: begin
            if (kk == 8'h9E) pc_d = pc2;
            else if (kk == 8'hA1) pc_d = pc4;
            else sts_d = c8e_pkg::STS_UNKNOWN;
          end
          default: begin
            case (kk)
              8'h07: state_d = c8e_pkg::S_WRX;
              8'h0A: pc_d = pc2;
              8'h15: begin dt_d = vx_q; pc_d = pc2; end
              8'h18: begin st_d = vx_q; pc_d = pc2; end
              8'h1E: begin
                alu_a = idx_q; alu_b = {8'd0, vx_q};
                idx_d = alu_res[15:0];
                pc_d = pc2;
              end
              8'h29: begin
                alu_a = {6'd0, vx_q, 2'd0}; alu_b = {8'd0, vx_q};
                tmp_d = alu_res[15:0];
                state_d = c8e_pkg::S_FNT;
              end
              8'h33: begin
                bt_d = vx_q; bh_d = 4'd0; btn_d = 4'd0;
                state_d = c8e_pkg::S_BCDH;
              end
              8'h55: begin cnt_d = 4'd0; state_d = c8e_pkg::S_STA; end
              8'h65: begin cnt_d = 4'd0; state_d = c8e_pkg::S_LDA; end
              default: sts_d = c8e_pkg::STS_UNKNOWN;
            endcase
          end
        endcase
        if (sts_d != c8e_pkg::STS_OK) begin
          halt_d = 1'b1;
          state_d = c8e_pkg::S_RESP;
        end
      end
      c8e_pkg::S_WRX: begin
        alu_a = {8'd0, vxe};
        alu_b = {8'd0, vye};
        case (ohi)
          4'h6: begin alu_op = c8e_pkg::ALU_PASSB; alu_b = {8'd0, kk}; end
          4'h7: alu_b = {8'd0, kk};
          4'hC: begin
            alu_op = c8e_pkg::ALU_AND;
            alu_a = {8'd0, item_q.random_byte}; alu_b = {8'd0, kk};
          end
          4'h8: begin
            case (on)
              4'h0: alu_op = c8e_pkg::ALU_PASSB;
              4'h1: alu_op = c8e_pkg::ALU_OR;
              4'h2: alu_op = c8e_pkg::ALU_AND;
              4'h3: alu_op = c8e_pkg::ALU_XOR;
              4'h5: alu_op = c8e_pkg::ALU_SUB;
              4'h6: alu_op = c8e_pkg::ALU_SHR;
              4'h7: begin
                alu_op = c8e_pkg::ALU_SUB;
                alu_a = {8'd0, vye}; alu_b = {8'd0, vxe};
              end
              4'hE: alu_op = c8e_pkg::ALU_SHL;
              default: ;
            endcase
          end
          default: begin alu_op = c8e_pkg::ALU_PASSB; alu_b = {8'd0, dt_q}; end
        endcase
        v_we = 1'b1;
        v_waddr = ox;
        v_wdata = alu_res[7:0];
        pc_d = pc2;
        state_d = c8e_pkg::S_RESP;
      end
      c8e_pkg::S_FNT: begin
        alu_a = {4'd0, fstart_q}; alu_b = tmp_q;
        idx_d = alu_res[15:0];
        pc_d = pc2;
        state_d = c8e_pkg::S_RESP;
      end
      c8e_pkg::S_BCDH: begin
        alu_op = c8e_pkg::ALU_SUB;
        alu_a = {8'd0, bt_q}; alu_b = 16'd100;
        if (!alu_res[16]) begin
          bt_d = alu_res[7:0];
          bh_d = bh_q + 4'd1;
        end else begin
          state_d = c8e_pkg::S_BCDT;
        end
      end
      c8e_pkg::S_BCDT: begin
        alu_op = c8e_pkg::ALU_SUB;
        alu_a = {8'd0, bt_q}; alu_b = 16'd10;
        if (!alu_res[16]) begin
          bt_d = alu_res[7:0];
          btn_d = btn_q + 4'd1;
        end else begin
          cnt_d = 4'd0;
          state_d = c8e_pkg::S_BCDW;
        end
      end
      c8e_pkg::S_BCDW: begin
        alu_a = idx_q; alu_b = {12'd0, cnt_q};
        mem_we = 1'b1;
        mem_waddr = alu_res[MAW-1:0];
        mem_wdata = (cnt_q == 4'd0) ? {4'd0, bh_q} :
                    (cnt_q == 4'd1) ? {4'd0, btn_q} : bt_q;
        if (cnt_q == 4'd2) begin
          pc_d = pc2;
          state_d = c8e_pkg::S_RESP;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      c8e_pkg::S_STA: begin
        v_raddr = cnt_q;
        state_d = c8e_pkg::S_STB;
      end
      c8e_pkg::S_STB: begin
        alu_a = idx_q; alu_b = {12'd0, cnt_q};
        mem_we = 1'b1;
        mem_waddr = alu_res[MAW-1:0];
        mem_wdata = vrd;
        if (cnt_q == ox) begin
          pc_d = pc2;
          state_d = c8e_pkg::S_RESP;
        end else begin
          cnt_d = cnt_q + 4'd1;
          state_d = c8e_pkg::S_STA;
        end
      end
      c8e_pkg::S_LDA: begin
        alu_a = idx_q; alu_b = {12'd0, cnt_q};
        mem_raddr = alu_res[MAW-1:0];
        state_d = c8e_pkg::S_LDB;
      end
      c8e_pkg::S_LDB: begin
        v_we = 1'b1;
        v_waddr = cnt_q;
        v_wdata = mem_rdata;
        if (cnt_q == ox) begin
          pc_d = pc2;
          state_d = c8e_pkg::S_RESP;
        end else begin
          cnt_d = cnt_q + 4'd1;
          state_d = c8e_pkg::S_LDA;
        end
      end
      c8e_pkg::S_DRA: begin
        alu_a = idx_q; alu_b = {12'd0, cnt_q};
        mem_raddr = alu_res[MAW-1:0];
        d_raddr = drow_addr;
        state_d = c8e_pkg::S_DRB;
      end
      c8e_pkg::S_DRB: begin
        d_we = 1'b1;
        rowv_d[drow_addr] = 1'b1;
        rownz_d[drow_addr] = |nrow;
        if (|(drow & mask)) coll_d = 1'b1;
        if (|mask) chg_d = 1'b1;
        if (cnt_q == on - 4'd1) begin
          state_d = c8e_pkg::S_DRF;
        end else begin
          cnt_d = cnt_q + 4'd1;
          state_d = c8e_pkg::S_DRA;
        end
      end
      c8e_pkg::S_DRF: begin
        v_we = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, coll_q};
        pc_d = pc2;
        state_d = c8e_pkg::S_RESP;
      end
      c8e_pkg::S_RESP: begin
        out_d.status = sts_q;
        out_d.pc = pc_q;
        out_d.opcode = op_q;
        out_d.read_data = rd_q;
        out_d.pixel_value = pix_q;
        out_d.display_changed = chg_q;
        out_d.sound_on = (st_q != 8'd0);
        out_valid_d = 1'b1;
        state_d = c8e_pkg::S_IDLE;
      end
      default: state_d = c8e_pkg::S_IDLE;
    endcase

    if (v_we) begin
      vval_d[v_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c8e_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pc_q <= 12'd512;
      pstart_q <= 12'd512;
      fstart_q <= 12'd80;
      idx_q <= 16'd0;
      sp_q <= '0;
      dt_q <= 8'd0;
      st_q <= 8'd0;
      halt_q <= 1'b0;
      vval_q <= '0;
      rowv_q <= '0;
      rownz_q <= '0;
      vrv_q <= 1'b0;
      drv_q <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_q[i] <= 12'd0;
      end
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      pc_q <= pc_d;
      pstart_q <= pstart_d;
      fstart_q <= fstart_d;
      idx_q <= idx_d;
      sp_q <= sp_d;
      dt_q <= dt_d;
      st_q <= st_d;
      halt_q <= halt_d;
      vval_q <= vval_d;
      rowv_q <= rowv_d;
      rownz_q <= rownz_d;
      vrv_q <= vval_q[v_raddr];
      drv_q <= rowv_q[d_raddr];
      if (stk_we) begin
        stk_q[sp_q] <= pc2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q <= out_d;
    op_q <= op_d;
    tmp_q <= tmp_d;
    vx_q <= vx_d;
    vy_q <= vy_d;
    bt_q <= bt_d;
    bh_q <= bh_d;
    btn_q <= btn_d;
    cnt_q <= cnt_d;
    rd_q <= rd_d;
    sts_q <= sts_d;
    flag_q <= flag_d;
    coll_q <= coll_d;
    chg_q <= chg_d;
    pix_q <= pix_d;
  end

endmodule
`default_nettype wire
